// File: rtl/core/dahp_pkg.sv
// shared types, codes and key name tables for the digest header parser
`default_nettype none
package dahp_pkg;

  localparam int FIELD_COUNT = 5;
  localparam logic [2:0] NO_FIELD = 3'd5;
  localparam logic [4:0] ALL_FIELDS = 5'h1f;

  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_EQUAL = 8'h3d;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  // result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_COMMIT = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  // byte classes decided by the front end
  typedef enum logic [2:0] {
    CLS_ALNUM,
    CLS_QUOTE,
    CLS_EQUAL,
    CLS_NUL,
    CLS_OTHER
  } cls_t;

  typedef struct packed {
    logic [7:0] data;
    logic [7:0] lower;
    cls_t cls;
  } tok_t;

  // length of each field name
  function automatic logic [3:0] field_len(input logic [2:0] idx);
    logic [3:0] len;
    unique case (idx)
      3'd0: len = 4'd8;
      3'd1: len = 4'd5;
      3'd2: len = 4'd5;
      3'd3: len = 4'd3;
      3'd4: len = 4'd8;
      default: len = 4'd0;
    endcase
    return len;
  endfunction

  // character of a field name at a given position, lower case
  function automatic logic [7:0] name_char(input logic [2:0] idx, input logic [3:0] pos);
    logic [63:0] name;
    logic [2:0] sel;
    unique case (idx)
      3'd0: name = "username";
      3'd1: name = {"realm", 24'h0};
      3'd2: name = {"nonce", 24'h0};
      3'd3: name = {"uri", 40'h0};
      3'd4: name = "response";
      default: name = 64'h0;
    endcase
    sel = 3'd7 - pos[2:0];
    return pos[3] ? 8'h00 : name[{sel, 3'b000} +: 8];
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/dahp_front.sv
// front end: classifies each header byte and hands it to the token queue
`default_nettype none
module dahp_front
  import dahp_pkg::*;
(
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] header_byte,
  input  wire logic       q_ready,
  output logic            q_push,
  output tok_t            q_tok
);

  logic is_digit;
  logic is_upper;
  logic is_lower;

  assign is_digit = (header_byte >= 8'h30) && (header_byte <= 8'h39);
  assign is_upper = (header_byte >= 8'h41) && (header_byte <= 8'h5a);
  assign is_lower = (header_byte >= 8'h61) && (header_byte <= 8'h7a);

  assign in_ready = q_ready;
  assign q_push = in_valid && q_ready;

  always_comb begin
    q_tok.data = header_byte;
    q_tok.lower = is_upper ? header_byte + 8'h20 : header_byte;
    priority if (is_digit || is_upper || is_lower) begin
      q_tok.cls = CLS_ALNUM;
    end else if (header_byte == CHAR_QUOTE) begin
      q_tok.cls = CLS_QUOTE;
    end else if (header_byte == CHAR_EQUAL) begin
      q_tok.cls = CLS_EQUAL;
    end else if (header_byte == CHAR_NUL) begin
      q_tok.cls = CLS_NUL;
    end else begin
      q_tok.cls = CLS_OTHER;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/dahp_queue.sv
// small token queue between the front end and the parser
`default_nettype none
module dahp_queue
  import dahp_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire tok_t push_tok,
  output logic      push_ready,
  input  wire logic pop,
  output logic      pop_valid,
  output tok_t      pop_tok
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tok_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic do_push;
  logic do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_tok = mem[rd_ptr];
  assign do_push = push && push_ready;
  assign do_pop = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/dahp_back.sv
// back end: key, value and quoted-string parser with its output register
`default_nettype none
module dahp_back
  import dahp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       tok_valid,
  input  wire tok_t       tok,
  output logic            tok_pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      kind,
  output logic [2:0]      field_id,
  output logic [7:0]      value_byte,
  output logic [4:0]      present_mask,
  output logic            complete,
  output logic            last_of_run
);

  typedef enum logic [1:0] {
    MODE_KEY,
    MODE_VALUE,
    MODE_QUOTED,
    MODE_SPARE
  } mode_t;

  mode_t mode, mode_next;
  logic [3:0] key_pos, key_pos_next;
  logic [4:0] cands, cands_next;
  logic [2:0] cur, cur_next;
  logic [4:0] seen, seen_next;

  logic can_load;
  logic known;
  logic emit;
  logic [1:0] r_kind;
  logic [2:0] r_field;
  logic [7:0] r_byte;
  logic [4:0] r_mask;
  logic r_last;
  logic do_finish;
  logic [4:0] match_cands;
  logic [2:0] close_field;

  assign can_load = !out_valid || out_ready;
  assign known = (cur < NO_FIELD);

  // per-name compare of the incoming key character
  always_comb begin
    for (int i = 0; i < FIELD_COUNT; i++) begin
      match_cands[i] = cands[i] && (key_pos < field_len(3'(i))) &&
                       (name_char(3'(i), key_pos) == tok.lower);
    end
  end

  // name whose full length was matched when '=' arrives
  always_comb begin
    close_field = NO_FIELD;
    for (int i = 0; i < FIELD_COUNT; i++) begin
      if (cands[i] && (field_len(3'(i)) == key_pos)) begin
        close_field = 3'(i);
      end
    end
  end

  always_comb begin
    mode_next = mode;
    key_pos_next = key_pos;
    cands_next = cands;
    cur_next = cur;
    seen_next = seen;
    tok_pop = 1'b0;
    emit = 1'b0;
    do_finish = 1'b0;
    r_kind = KIND_BYTE;
    r_field = cur;
    r_byte = tok.data;
    r_mask = '0;
    r_last = 1'b1;
    if (tok_valid && can_load) begin
      tok_pop = 1'b1;
      unique case (mode)
        MODE_QUOTED: begin
          if (tok.cls == CLS_QUOTE) begin
            mode_next = MODE_VALUE;
          end else if (tok.cls == CLS_NUL) begin
            do_finish = 1'b1;
          end else begin
            emit = known;
          end
        end
        MODE_VALUE: begin
          priority if (tok.cls == CLS_ALNUM) begin
            emit = known;
          end else if (tok.cls == CLS_QUOTE) begin
            mode_next = MODE_QUOTED;
          end else if (known) begin
            // commit; a NUL terminator stays queued and finishes once the output register can load
            emit = 1'b1;
            r_kind = KIND_COMMIT;
            r_byte = '0;
            r_last = (tok.cls != CLS_NUL);
            tok_pop = (tok.cls != CLS_NUL);
            seen_next = seen | (5'b00001 << cur);
            cur_next = NO_FIELD;
            mode_next = MODE_KEY;
          end else if (tok.cls == CLS_NUL) begin
            do_finish = 1'b1;
          end else begin
            cur_next = NO_FIELD;
            mode_next = MODE_KEY;
          end
        end
        MODE_KEY, MODE_SPARE: begin
          priority if (tok.cls == CLS_ALNUM) begin
            cands_next = match_cands;
            key_pos_next = (key_pos == 4'hf) ? key_pos : key_pos + 4'd1;
          end else if (tok.cls == CLS_EQUAL) begin
            cur_next = close_field;
            key_pos_next = '0;
            cands_next = ALL_FIELDS;
            mode_next = MODE_VALUE;
          end else if (tok.cls == CLS_NUL) begin
            do_finish = 1'b1;
          end else begin
            mode_next = mode;
          end
        end
        default: begin
          mode_next = MODE_KEY;
        end
      endcase
      if (do_finish) begin
        emit = 1'b1;
        r_kind = KIND_FINISH;
        r_field = '0;
        r_byte = '0;
        r_mask = seen;
        r_last = 1'b1;
        mode_next = MODE_KEY;
        key_pos_next = '0;
        cands_next = ALL_FIELDS;
        cur_next = NO_FIELD;
        seen_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_KEY;
      key_pos <= '0;
      cands <= ALL_FIELDS;
      cur <= NO_FIELD;
      seen <= '0;
      out_valid <= 1'b0;
    end else begin
      mode <= mode_next;
      key_pos <= key_pos_next;
      cands <= cands_next;
      cur <= cur_next;
      seen <= seen_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind <= r_kind;
      field_id <= r_field;
      value_byte <= r_byte;
      present_mask <= r_mask;
      complete <= (r_kind == KIND_FINISH) && (r_mask == ALL_FIELDS);
      last_of_run <= r_last;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/digest_auth_header_parser_unit.sv
// top level of the digest authorization header parser
//
//  channel   dir   handshake               payload
//  -------   ---   ---------------------   ---------------------------------
//  input     in    in_valid / in_ready     header_byte
//  output    out   out_valid / out_ready   kind, field_id, value_byte,
//                                          present_mask, complete, last_of_run
//
// one header byte a cycle while the token queue has room; each byte gives at most
// one result a cycle from the parser, so a NUL that closes a known value gives
// a commit and then a finish at the parser stage
// an accepted byte passes the token queue and output register to result valid
// reset clears the parser state, the token queue and the output valid
// input stalls only when the token queue is full; the parser stalls only
// while the output register holds an unaccepted result
`default_nettype none
module digest_auth_header_parser_unit
  import dahp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] header_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      kind,
  output logic [2:0]      field_id,
  output logic [7:0]      value_byte,
  output logic [4:0]      present_mask,
  output logic            complete,
  output logic            last_of_run
);

  // classified request from the front end
  logic q_ready;
  logic q_push;
  tok_t q_tok;

  // head of the queue seen by the parser
  logic head_valid;
  logic head_pop;
  tok_t head_tok;

  // front end: byte classification and case folding
  dahp_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .header_byte (header_byte),
    .q_ready     (q_ready),
    .q_push      (q_push),
    .q_tok       (q_tok)
  );

  // decouples input acceptance from result backpressure
  dahp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_tok   (q_tok),
    .push_ready (q_ready),
    .pop        (head_pop),
    .pop_valid  (head_valid),
    .pop_tok    (head_tok)
  );

  // parser state machine and result register
  dahp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .tok_valid    (head_valid),
    .tok          (head_tok),
    .tok_pop      (head_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .field_id     (field_id),
    .value_byte   (value_byte),
    .present_mask (present_mask),
    .complete     (complete),
    .last_of_run  (last_of_run)
  );

`ifndef SYNTHESIS
  // a finish always closes the run of its byte
  a_finish_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_FINISH) |-> last_of_run)
    else $error("finish result without last_of_run");

  // complete agrees with the reported mask
  a_complete_mask: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_FINISH) |-> (complete == (present_mask == ALL_FIELDS)))
    else $error("complete disagrees with present_mask");

  // a commit that is not last belongs to a terminator: finish follows at once
  a_commit_then_finish: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && (kind == KIND_COMMIT) && !last_of_run
    |=> out_valid && (kind == KIND_FINISH))
    else $error("terminator commit not followed by finish");

  // only value byte results carry a byte
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != KIND_BYTE) |-> (value_byte == 8'h00))
    else $error("value_byte set on a non-byte result");
`endif

endmodule
`default_nettype wire
